@@ hw/rtl/rms_sound_level_meter_top_macros.svh @@
// Assertion macros shared by the RMS level meter RTL.
// Each property is clocked on the rising edge and disabled while reset is low.
`ifndef RMS_SOUND_LEVEL_METER_TOP_MACROS_SVH
`define RMS_SOUND_LEVEL_METER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold in the same cycle as its condition.
`define RSM_ASSERT_SAME(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its condition.
`define RSM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define RSM_ASSERT_SAME(lbl, clk, rst_n, cond, prop, msg)

`define RSM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

@@ hw/rtl/rsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rsm_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_LEVELS     = 5;
    localparam int DEF_COUNT_BITS = 20;

    // Field and register widths.
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 52;
    localparam int RMS_W     = 16;
    localparam int LEVEL_W   = 3;
    localparam int NF_W      = 15;
    localparam int FS_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 1'd1;
    localparam logic [NF_W-1:0]      NF_RESET        = 15'd20;
    localparam logic [FS_W-1:0]      FS_RESET        = 16'd2000;

    // Request kinds carried in tuser.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Operations of the iterative engine.
    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    // Command from the sequencer to the engine.
    typedef struct packed {
        logic start;
        logic mode;
    } rsm_eng_ctl_t;

    // Status from the engine back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } rsm_eng_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rms_sound_level_meter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Group                      Payload
// --------  -------------------------  ------------------------------------------
// input     s_tvalid/s_tready          s_tdata: sample; s_tuser: req_type
// output    m_tvalid/m_tready          m_tdata: rms, level, empty_res
// config    cfg_we/cfg_addr/cfg_wdata  0 = noise_floor, 1 = full_scale
//
// Samples may arrive on every cycle while no report tick is being processed.
// A report tick holds the input off until its result is registered. When a level is
// mapped it runs two divides of 52 steps and two square roots of 26 steps through
// the one compare-subtract unit in rsm_engine, plus the sequencing states.
// At or below the noise floor it runs one divide and one root; with no samples, none.
// A finished result waits in the output register; samples keep flowing meanwhile.
// A tick that finishes while a result still waits stalls until that word leaves.
// Reset clears the sum, the count and all handshake state.
module rms_sound_level_meter_top #(
    parameter int LEVELS     = rsm_pkg::DEF_LEVELS,
    parameter int COUNT_BITS = rsm_pkg::DEF_COUNT_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rsm_pkg::IN_W-1:0]       s_tdata,   // [15:0] sample
    input  wire logic                           s_tuser,   // [0] req_type
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rsm_pkg::OUT_W-1:0]           m_tdata,   // [15:0] rms, [18:16] level,
                                                           // [19] empty_res, [23:20] zero
    // Configuration writes.
    input  wire logic                           cfg_we,
    input  wire logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [rsm_pkg::CFG_W-1:0]      cfg_wdata
);

    import rsm_pkg::*;

`include "rms_sound_level_meter_top_macros.svh"

    localparam int NW    = SUM_W;
    localparam int RW    = NW / 2;
    localparam int DEN_W = (COUNT_BITS > FS_W) ? COUNT_BITS : FS_W;
    localparam int L2    = LEVELS * LEVELS;
    localparam int L2W   = $clog2(L2 + 1);
    localparam int SQ_W  = 2 * (SAMPLE_W + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_SQ1  = 4'd3;
    localparam logic [3:0] S_LVL  = 4'd4;
    localparam logic [3:0] S_LDIV = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_SQ2  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [NF_W-1:0]       nf_reg;
    logic [FS_W-1:0]       fs_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  sq_valid_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [RW-1:0]         rms_reg, rms_next;
    logic [LEVEL_W-1:0]    lvl_reg, lvl_next;
    logic                  empty_reg, empty_next;
    logic [NW-1:0]         x_reg, x_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic                  in_fire;
    logic                  out_fire;
    logic [SAMPLE_W:0]     mag;
    logic [SUM_W:0]        sum_add;
    logic [RW-1:0]         nf_ext;
    logic [RW-1:0]         rms_above;
    logic [L2W-1:0]        l2_c;
    logic [RW+L2W-1:0]     prod;
    logic [DEN_W-1:0]      fs_eff;
    logic [RW-1:0]         lvl_full;

    rsm_eng_ctl_t          eng_ctl;
    rsm_eng_sts_t          eng_sts;
    logic [NW-1:0]         eng_a;
    logic [DEN_W-1:0]      eng_d;
    logic [NW-1:0]         eng_quo;
    logic [RW-1:0]         eng_root;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg <= NF_RESET;
            fs_reg <= FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NOISE_FLOOR: nf_reg <= cfg_wdata[NF_W-1:0];
                REG_FULL_SCALE:  fs_reg <= cfg_wdata[FS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Magnitude of the sample; its square is registered before accumulation.
    assign mag = s_tdata[SAMPLE_W-1] ? ((SAMPLE_W + 1)'(0) - {1'b1, s_tdata})
                                     : {1'b0, s_tdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= in_fire && (s_tuser == REQ_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= mag * mag;
    end

    // Saturating accumulation of squares and count; a tick load clears both.
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (state_reg == S_LOAD)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (sq_valid_reg)
        begin
            sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            if (!(&count_reg))
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Level mapping arithmetic.
    assign nf_ext    = RW'(nf_reg);
    assign rms_above = rms_reg - nf_ext;
    assign l2_c      = L2W'(L2);
    assign prod      = (RW + L2W)'(rms_above) * (RW + L2W)'(l2_c);
    assign fs_eff    = (fs_reg == '0) ? DEN_W'(1) : DEN_W'(fs_reg);
    assign lvl_full  = (eng_root > RW'(LEVELS - 1)) ? RW'(LEVELS - 1) : eng_root;

    // Engine commands.
    always_comb
    begin
        eng_ctl.start = 1'b0;
        eng_ctl.mode  = MODE_DIV;
        eng_a         = eng_quo;
        eng_d         = fs_eff;
        case (state_reg)
            S_LOAD:
            begin
                eng_ctl.start = (count_reg != '0);
                eng_a         = sum_reg;
                eng_d         = DEN_W'(count_reg);
            end
            S_DIV1, S_DIV2:
            begin
                eng_ctl.start = eng_sts.done;
                eng_ctl.mode  = MODE_SQRT;
            end
            S_LDIV:
            begin
                eng_ctl.start = 1'b1;
                eng_a         = x_reg;
            end
            default: ;
        endcase
    end

    rsm_engine #(
        .NW    (NW),
        .DEN_W (DEN_W)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (eng_ctl),
        .opa   (eng_a),
        .den   (eng_d),
        .sts   (eng_sts),
        .quo   (eng_quo),
        .root  (eng_root)
    );

    // Tick sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rms_next       = rms_reg;
        lvl_next       = lvl_reg;
        empty_next     = empty_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg && !out_fire;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (s_tuser == REQ_TICK))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rms_next = '0;
                lvl_next = '0;
                if (count_reg == '0)
                begin
                    empty_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    empty_next = 1'b0;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (eng_sts.done)
                begin
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                if (eng_sts.done)
                begin
                    rms_next   = eng_root;
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                if (rms_reg > nf_ext)
                begin
                    x_next     = NW'(prod);
                    state_next = S_LDIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LDIV:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (eng_sts.done)
                begin
                    state_next = S_SQ2;
                end
            end
            S_SQ2:
            begin
                if (eng_sts.done)
                begin
                    lvl_next   = lvl_full[LEVEL_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({empty_reg, lvl_reg, rms_reg[RMS_W-1:0]});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rms_reg      <= rms_next;
        lvl_reg      <= lvl_next;
        empty_reg    <= empty_next;
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
    end

    // A tick load clears the accumulators on the following cycle.
    `RSM_ASSERT_NEXT(a_tick_clears, clk, rst_n, state_reg == S_LOAD,
        (sum_reg == '0) && (count_reg == '0), "accumulators not cleared by tick")

    // A tick with samples starts the engine.
    `RSM_ASSERT_NEXT(a_load_starts, clk, rst_n, (state_reg == S_LOAD) && (count_reg != '0),
        eng_sts.busy, "engine did not start on tick")

    // An empty report carries zero rms and level.
    `RSM_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid_reg && out_data_reg[RMS_W+LEVEL_W],
        out_data_reg[RMS_W+LEVEL_W-1:0] == '0, "empty report with nonzero fields")

    // The level stays within the scale whenever the scale fits the field.
    `RSM_ASSERT_SAME(a_level_range, clk, rst_n, out_valid_reg && (LEVELS <= 8),
        out_data_reg[RMS_W+LEVEL_W-1:RMS_W] <= LEVEL_W'(LEVELS - 1), "level out of range")

endmodule

`default_nettype wire

@@ hw/rtl/rsm_csub.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared compare-and-subtract unit: one restoring step of divide or square root.
module rsm_csub #(
    parameter int W = 28
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);

    logic borrow;

    // A borrow out of the subtraction means a is below b.
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge             = ~borrow;

endmodule

`default_nettype wire

@@ hw/rtl/rsm_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Iterative divider and square root built around one compare-subtract unit.
// Divide takes one step per numerator bit, square root one step per bit pair.
module rsm_engine #(
    parameter int NW    = 52,
    parameter int DEN_W = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsm_pkg::rsm_eng_ctl_t ctl,
    input  wire logic [NW-1:0]         opa,
    input  wire logic [DEN_W-1:0]      den,
    output rsm_pkg::rsm_eng_sts_t      sts,
    output logic [NW-1:0]              quo,
    output logic [NW/2-1:0]            root
);

    import rsm_pkg::*;

    localparam int RW    = NW / 2;
    localparam int UW    = (DEN_W + 1 > RW + 2) ? DEN_W + 1 : RW + 2;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    acc_reg, acc_next;
    logic [UW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [UW-1:0]    trial;
    logic [UW-1:0]    subtrahend;
    logic             ge;
    logic [UW-1:0]    diff;

    // Operands of the current step.
    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            trial      = {rem_reg[UW-2:0], acc_reg[NW-1]};
            subtrahend = UW'(den_reg);
        end
        else
        begin
            trial      = {rem_reg[UW-3:0], acc_reg[NW-1:NW-2]};
            subtrahend = UW'({root_reg, 2'b01});
        end
    end

    rsm_csub #(
        .W (UW)
    ) u_csub (
        .a    (trial),
        .b    (subtrahend),
        .ge   (ge),
        .diff (diff)
    );

    // Step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        den_next  = den_reg;
        if (busy_reg)
        begin
            rem_next = ge ? diff : trial;
            cnt_next = cnt_reg - CNT_W'(1);
            if (mode_reg == MODE_DIV)
            begin
                acc_next = {acc_reg[NW-2:0], ge};
            end
            else
            begin
                acc_next  = {acc_reg[NW-3:0], 2'b00};
                root_next = {root_reg[RW-2:0], ge};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            acc_next  = opa;
            rem_next  = '0;
            root_next = '0;
            den_next  = den;
            cnt_next  = (ctl.mode == MODE_DIV) ? CNT_W'(NW) : CNT_W'(RW);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        den_reg  <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = acc_reg;
    assign root     = root_reg;

endmodule

`default_nettype wire

@@ dv/rms_sound_level_meter_top_tb.sv @@
`timescale 1ns / 1ps

module rms_sound_level_meter_top_tb;
    import rsm_pkg::*;

    localparam int LEVELS     = DEF_LEVELS;
    localparam int COUNT_BITS = DEF_COUNT_BITS;

    localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

    // This pause outlasts a full tick with margin.
    localparam int DRAIN_PAUSE = 200;

    // Pairs of full-scale words of both signs sent back to back.
    localparam int LOUD_RUN = 16;

    // One report as it appears in the low bits of m_tdata.
    typedef struct packed {
        logic               is_empty;
        logic [LEVEL_W-1:0] level;
        logic [RMS_W-1:0]   rms;
    } meter_report_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow of the meter: running sums and the two registers.
    logic [SUM_W-1:0]      acc_sq;
    logic [COUNT_BITS-1:0] n_samples;
    logic [NF_W-1:0]       nf_reg;
    logic [FS_W-1:0]       fs_reg;

    // Reports owed by the meter, oldest first.
    meter_report_t pending_reports[$];

    // When set, neither side inserts idle cycles.
    bit steady_phase = 1'b0;

    int mismatch_count  = 0;
    int reports_checked = 0;
    int samples_sent    = 0;
    int ticks_sent      = 0;
    int register_writes = 0;

    rms_sound_level_meter_top #(
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Integer square root, floor, built one result bit at a time.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Idle cycles before the next word on either side.
    function automatic int draw_wait();
        if (steady_phase)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Update the shadow meter with one accepted word. A tick owes a report.
    task automatic meter_absorb(input logic kind, input logic [IN_W-1:0] data);
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned span;
        longint unsigned lvl;
        longint unsigned divisor;
        meter_report_t   rep;
        if (kind == REQ_SAMPLE)
        begin
            mag = data[IN_W-1] ? 64'd65536 - 64'(data) : 64'(data);
            sq  = mag * mag;
            if (64'(acc_sq) > SUM_LIMIT - sq)
                acc_sq = SUM_LIMIT[SUM_W-1:0];
            else
                acc_sq = acc_sq + sq[SUM_W-1:0];
            if (64'(n_samples) != COUNT_LIMIT)
                n_samples = n_samples + 1'b1;
            samples_sent++;
        end
        else
        begin
            rep = '0;
            if (n_samples == 0)
            begin
                rep.is_empty = 1'b1;
            end
            else
            begin
                root    = floor_root(64'(acc_sq) / 64'(n_samples));
                rep.rms = root[RMS_W-1:0];
                // Only the part above the noise floor maps onto the level scale.
                if (root > 64'(nf_reg))
                begin
                    divisor = (fs_reg == 0) ? 64'd1 : 64'(fs_reg);
                    span    = (root - 64'(nf_reg)) * 64'(LEVELS * LEVELS) / divisor;
                    lvl     = floor_root(span);
                    if (lvl > 64'(LEVELS - 1))
                        lvl = 64'(LEVELS - 1);
                    rep.level = lvl[LEVEL_W-1:0];
                end
            end
            acc_sq    = '0;
            n_samples = '0;
            pending_reports.push_back(rep);
            ticks_sent++;
        end
    endtask

    // Offer one word on the input stream and wait until it is taken.
    task automatic push_word(input logic kind, input logic [IN_W-1:0] data);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        meter_absorb(kind, data);
    endtask

    // Write a register once the meter has gone quiet.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NOISE_FLOOR)
            nf_reg = value[NF_W-1:0];
        else
            fs_reg = value[FS_W-1:0];
        register_writes++;
    endtask

    // Ticks with nothing accumulated, right after reset and back to back.
    task automatic test_empty_reports();
        push_word(REQ_TICK, 16'h0000);
        push_word(REQ_TICK, 16'hFFFF);
    endtask

    // Field extremes and alternating bit patterns, then a lone full-scale word.
    task automatic test_sample_extremes();
        push_word(REQ_SAMPLE, 16'h7FFF);
        push_word(REQ_SAMPLE, 16'h8000);
        push_word(REQ_SAMPLE, 16'h0000);
        push_word(REQ_SAMPLE, 16'hFFFF);
        push_word(REQ_SAMPLE, 16'h0001);
        push_word(REQ_SAMPLE, 16'h5555);
        push_word(REQ_SAMPLE, 16'hAAAA);
        push_word(REQ_TICK, 16'h5555);
        push_word(REQ_SAMPLE, 16'h8000);
        push_word(REQ_TICK, 16'hAAAA);
    endtask

    // RMS exactly at the noise floor, just above it, and well above it.
    task automatic test_noise_floor_edge();
        push_word(REQ_SAMPLE, 16'd20);
        push_word(REQ_SAMPLE, -16'sd20);
        push_word(REQ_TICK, 16'h0000);
        push_word(REQ_SAMPLE, 16'd21);
        push_word(REQ_TICK, 16'h0000);
        push_word(REQ_SAMPLE, 16'd400);
        push_word(REQ_TICK, 16'h0000);
    endtask

    // Smallest and largest register values, including a zero full scale
    // and a write whose top bit lies outside the noise floor field.
    task automatic test_register_extremes();
        write_register(REG_NOISE_FLOOR, 16'd0);
        write_register(REG_FULL_SCALE, 16'd1);
        push_word(REQ_SAMPLE, 16'd1);
        push_word(REQ_TICK, 16'h0000);
        write_register(REG_FULL_SCALE, 16'd0);
        push_word(REQ_SAMPLE, 16'd2);
        push_word(REQ_TICK, 16'h0000);
        write_register(REG_NOISE_FLOOR, 16'hFFFF);
        write_register(REG_FULL_SCALE, 16'hFFFF);
        push_word(REQ_SAMPLE, 16'h8000);
        push_word(REQ_TICK, 16'h0000);
        push_word(REQ_SAMPLE, 16'h7FFF);
        push_word(REQ_TICK, 16'h0000);
        write_register(REG_NOISE_FLOOR, CFG_W'(NF_RESET));
        write_register(REG_FULL_SCALE, FS_RESET);
    endtask

    // Loudest input back to back, then a clean restart with a quiet word.
    task automatic test_loud_run();
        steady_phase = 1'b1;
        repeat (LOUD_RUN)
        begin
            push_word(REQ_SAMPLE, 16'h8000);
            push_word(REQ_SAMPLE, 16'h7FFF);
        end
        push_word(REQ_TICK, 16'h0000);
        push_word(REQ_SAMPLE, 16'd3);
        push_word(REQ_TICK, 16'h0000);
        steady_phase = 1'b0;
    endtask

    // Bursts of samples closed by a tick, with random register settings per
    // phase and some stray words mixed in.
    task automatic test_random_traffic(input int item_goal);
        int              sent;
        int              bursts;
        int              len;
        int              amp_bits;
        int              pick;
        logic [IN_W-1:0] mag;
        logic [CFG_W-1:0] value;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(0, 4);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = CFG_W'($urandom);
            else
                value = CFG_W'($urandom_range(0, 400));
            write_register(REG_NOISE_FLOOR, value);
            pick = $urandom_range(0, 5);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = 16'hFFFF;
            else if (pick == 2)
                value = CFG_W'($urandom);
            else
                value = CFG_W'($urandom_range(1, 5000));
            write_register(REG_FULL_SCALE, value);
            steady_phase = ($urandom_range(0, 3) == 0);
            bursts = 0;
            while (bursts < 10 && sent < item_goal)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    // Stray words of either kind with arbitrary data.
                    len = $urandom_range(1, 6);
                    repeat (len) push_word(1'($urandom_range(0, 1)), IN_W'($urandom));
                    sent += len;
                end
                else
                begin
                    len      = (pick < 8) ? $urandom_range(0, 20) : $urandom_range(21, 150);
                    amp_bits = $urandom_range(0, 15);
                    repeat (len)
                    begin
                        mag = IN_W'($urandom_range(0, (1 << amp_bits) - 1));
                        if ($urandom_range(0, 1) == 1)
                            mag = -mag;
                        push_word(REQ_SAMPLE, mag);
                    end
                    push_word(REQ_TICK, IN_W'($urandom));
                    sent += len + 1;
                end
                bursts++;
            end
        end
        steady_phase = 1'b0;
    endtask

    // Result side: random back-pressure, each report compared with the oldest
    // one owed.
    initial
    begin : report_monitor
        meter_report_t want;
        meter_report_t got;
        int            stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata[$bits(meter_report_t)-1:0];
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: report with none expected, expected nothing, actual %h",
                         $time, got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.rms !== want.rms)
                begin
                    mismatch_count++;
                    $display("%0t: rms mismatch, expected %0d, actual %0d",
                             $time, want.rms, got.rms);
                end
                if (got.level !== want.level)
                begin
                    mismatch_count++;
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, want.level, got.level);
                end
                if (got.is_empty !== want.is_empty)
                begin
                    mismatch_count++;
                    $display("%0t: empty_res mismatch, expected %0b, actual %0b",
                             $time, want.is_empty, got.is_empty);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        acc_sq    = '0;
        n_samples = '0;
        nf_reg    = NF_RESET;
        fs_reg    = FS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reports();
        test_sample_extremes();
        test_noise_floor_edge();
        test_register_extremes();
        test_loud_run();
        test_random_traffic(700);

        // Let every owed report arrive, then watch for strays.
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);

        $display("Sent %0d samples and %0d ticks over %0d register writes,",
                 samples_sent, ticks_sent, register_writes);
        $display("with empty ticks, field extremes and random stalls; %0d reports checked, %0d mismatches.",
                 reports_checked, mismatch_count);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #20_000_000;
        $display("Run did not finish in the allowed time, %0d reports still owed.",
                 pending_reports.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
